// File: hdl/csvqs_pkg.sv
// ----------------------------------------------------------------------------
// CSV quoted field splitter package
// Shared item types, result kinds and command format for the front and the
// back of the splitter.
// ----------------------------------------------------------------------------
package csvqs_pkg;

   localparam int SPACE_BUFFER_DEPTH = 16;
   localparam int CNT_W = $clog2(SPACE_BUFFER_DEPTH + 1);
   localparam int IDX_W = (SPACE_BUFFER_DEPTH > 1) ? $clog2(SPACE_BUFFER_DEPTH) : 1;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_LINE_END  = 2'd2;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_END   = 2'd2
   } cmd_op_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] kind;
      logic       space_overflow;
      logic       last;
   } rsp_type;

   // For a store, count holds the buffer slot; for a character, the number
   // of buffered spaces that precede it.
   typedef struct packed {
      cmd_op_type       op;
      logic [7:0]       ch;
      logic [CNT_W-1:0] count;
      logic [1:0]       kind;
      logic             ovf;
   } cmd_type;

   function automatic logic is_ws(input logic [7:0] c);
      return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) || (c == 8'h85) ||
             (c == 8'hA0);
   endfunction

endpackage

// File: hdl/csvqs_front.sv
// ----------------------------------------------------------------------------
// CSV splitter front
// Tracks quoting and field state for each accepted item and turns it into at
// most one command for the back.
// ----------------------------------------------------------------------------
module csvqs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  csvqs_pkg::req_type item,
   output logic              push,
   output csvqs_pkg::cmd_type cmd
);

   logic                        inq_ff, inq_in;
   logic                        qsingle_ff, qsingle_in;
   logic                        pend_ff, pend_in;
   logic                        has_ff, has_in;
   logic                        ovf_ff, ovf_in;
   logic [csvqs_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      logic [7:0] c;
      logic [7:0] qc;
      logic       unq;
      logic       add;
      logic       do_end;
      logic [1:0] end_kind;

      c        = item.ch;
      qc       = qsingle_ff ? csvqs_pkg::CH_SQUOTE : csvqs_pkg::CH_DQUOTE;
      unq      = 1'b0;
      add      = 1'b0;
      do_end   = 1'b0;
      end_kind = csvqs_pkg::KIND_FIELD_END;
      inq_in     = inq_ff;
      qsingle_in = qsingle_ff;
      pend_in    = pend_ff;
      has_in     = has_ff;
      ovf_in     = ovf_ff;
      cnt_in     = cnt_ff;
      push       = 1'b0;
      cmd.op     = csvqs_pkg::CMD_END;
      cmd.ch     = c;
      cmd.count  = cnt_ff;
      cmd.kind   = csvqs_pkg::KIND_FIELD_END;
      cmd.ovf    = ovf_ff;

      if (item.end_of_line) begin
         do_end   = 1'b1;
         end_kind = csvqs_pkg::KIND_LINE_END;
      end else if (inq_ff && pend_ff) begin
         pend_in = 1'b0;
         if (c == qc) begin
            add = 1'b1;
         end else begin
            inq_in     = 1'b0;
            qsingle_in = 1'b0;
            unq        = 1'b1;
         end
      end else if (inq_ff) begin
         if (c == qc) begin
            pend_in = 1'b1;
         end else begin
            add = 1'b1;
         end
      end else begin
         unq = 1'b1;
      end

      if (unq) begin
         if (((c == csvqs_pkg::CH_DQUOTE) || (c == csvqs_pkg::CH_SQUOTE)) && !has_ff) begin
            inq_in     = 1'b1;
            qsingle_in = (c == csvqs_pkg::CH_SQUOTE);
            pend_in    = 1'b0;
         end else if (c == csvqs_pkg::CH_COMMA) begin
            do_end = 1'b1;
         end else begin
            add = 1'b1;
         end
      end

      if (add) begin
         if (csvqs_pkg::is_ws(c)) begin
            if (has_ff) begin
               if (cnt_ff < csvqs_pkg::CNT_W'(csvqs_pkg::SPACE_BUFFER_DEPTH)) begin
                  push   = 1'b1;
                  cmd.op = csvqs_pkg::CMD_STORE;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end else begin
            push   = 1'b1;
            cmd.op = csvqs_pkg::CMD_CHAR;
            cnt_in = '0;
            has_in = 1'b1;
         end
      end

      if (do_end) begin
         push       = 1'b1;
         cmd.op     = csvqs_pkg::CMD_END;
         cmd.kind   = end_kind;
         has_in     = 1'b0;
         cnt_in     = '0;
         ovf_in     = 1'b0;
         inq_in     = 1'b0;
         qsingle_in = 1'b0;
         pend_in    = 1'b0;
      end

      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff     <= 1'b0;
         qsingle_ff <= 1'b0;
         pend_ff    <= 1'b0;
         has_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         cnt_ff     <= '0;
      end else if (accept) begin
         inq_ff     <= inq_in;
         qsingle_ff <= qsingle_in;
         pend_ff    <= pend_in;
         has_ff     <= has_in;
         ovf_ff     <= ovf_in;
         cnt_ff     <= cnt_in;
      end
   end

endmodule

// File: hdl/csvqs_queue.sv
// ----------------------------------------------------------------------------
// CSV splitter command queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csvqs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csvqs_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output csvqs_pkg::cmd_type pop_data,
   output logic              empty
);

   csvqs_pkg::cmd_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/csvqs_back.sv
// ----------------------------------------------------------------------------
// CSV splitter back
// Executes commands: stores inner whitespace, drains it ahead of the next
// field character and sends characters and end marks through an output
// register.
// ----------------------------------------------------------------------------
module csvqs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  csvqs_pkg::cmd_type  pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csvqs_pkg::rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_SPACE = 4'b0100,
      S_LAST  = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   csvqs_pkg::cmd_type          cmd_ff, cmd_in;
   logic [csvqs_pkg::CNT_W-1:0] ptr_ff, ptr_in;
   logic [7:0]                  rd_data_ff;
   logic [7:0]                  mem [csvqs_pkg::SPACE_BUFFER_DEPTH];
   logic                        mem_we;
   logic                        rsp_valid_ff, rsp_valid_in;
   csvqs_pkg::rsp_type          rsp_ff, rsp_in;
   logic                        out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ptr_in       = ptr_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cmd_in = pop_data;
               if (pop_data.op == csvqs_pkg::CMD_STORE) begin
                  mem_we = 1'b1;
               end else if ((pop_data.op == csvqs_pkg::CMD_CHAR) && (pop_data.count != '0)) begin
                  ptr_in   = '0;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_LAST;
               end
            end
         end
         S_FETCH: begin
            state_in = S_SPACE;
         end
         S_SPACE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.out_char       = rd_data_ff;
               rsp_in.kind           = csvqs_pkg::KIND_CHAR;
               rsp_in.space_overflow = cmd_ff.ovf;
               rsp_in.last           = 1'b0;
               ptr_in                = ptr_ff + 1'b1;
               state_in = ((ptr_ff + 1'b1) == cmd_ff.count) ? S_LAST : S_FETCH;
            end
         end
         S_LAST: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.space_overflow = cmd_ff.ovf;
               rsp_in.last           = 1'b1;
               if (cmd_ff.op == csvqs_pkg::CMD_CHAR) begin
                  rsp_in.out_char = cmd_ff.ch;
                  rsp_in.kind     = csvqs_pkg::KIND_CHAR;
               end else begin
                  rsp_in.out_char = 8'h00;
                  rsp_in.kind     = cmd_ff.kind;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pop_data.count[csvqs_pkg::IDX_W-1:0]] <= pop_data.ch;
      end
      rd_data_ff <= mem[ptr_ff[csvqs_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/csv_quoted_field_splitter.sv
// A field character passes from the front into the command queue, is popped
// by the back and leaves from S_LAST through the output register; each buffered
// space sent ahead of it is read in S_FETCH and sent from S_SPACE. A stored space
// is written on its pop. The front takes new items while the queue is not full.
// Reset is synchronous; it clears quoting, field state, the queue and the
// output register. The whitespace buffer itself is not cleared.
// ----------------------------------------------------------------------------
// CSV quoted field splitter
// Splits a CSV line into trimmed fields, honoring double and single quotes.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  csvqs_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csvqs_pkg::rsp_type  rsp_data
);

   logic               accept;
   logic               push;
   logic               full;
   logic               pop;
   logic               empty;
   csvqs_pkg::cmd_type push_cmd;
   csvqs_pkg::cmd_type pop_cmd;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   csvqs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_data),
      .push   (push),
      .cmd    (push_cmd)
   );

   csvqs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .empty     (empty)
   );

   csvqs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_data  (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: dv/csv_field_checker.sv
// ----------------------------------------------------------------------------
// CSV field checker
// Watches both channels of the splitter and keeps its own copy of the quoting
// and whitespace state. Every accepted input item is split into the results
// it should cause. Each accepted result is compared field by field with the
// oldest one still due, and every mismatch is counted for the test top.
// ----------------------------------------------------------------------------
module csv_field_checker
   import csvqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending,
   output int      item_count,
   output int      result_count,
   output int      field_count
);

   logic       quoted;
   logic       single_quoted;
   logic       quote_seen;
   logic       has_text;
   logic       spaces_lost;
   logic [7:0] held_spaces [SPACE_BUFFER_DEPTH];
   int         held_count;
   rsp_type    results_due [$];
   rsp_type    item_results [$];

   function automatic logic is_blank(logic [7:0] c);
      return c inside {[8'h09:8'h0D], 8'h20, 8'h85, 8'hA0};
   endfunction

   function automatic void put(logic [7:0] c, logic [1:0] kind);
      rsp_type r;
      r.out_char = c;
      r.kind = kind;
      r.space_overflow = spaces_lost;
      r.last = 1'b0;
      item_results.push_back(r);
   endfunction

   function automatic void end_field();
      quoted = 1'b0;
      single_quoted = 1'b0;
      quote_seen = 1'b0;
      has_text = 1'b0;
      spaces_lost = 1'b0;
      held_count = 0;
   endfunction

   function automatic void take_char(logic [7:0] c);
      int i;
      if (is_blank(c)) begin
         if (has_text) begin
            if (held_count < SPACE_BUFFER_DEPTH) begin
               held_spaces[held_count] = c;
               held_count++;
            end else begin
               spaces_lost = 1'b1;
            end
         end
      end else begin
         for (i = 0; i < held_count; i++) put(held_spaces[i], KIND_CHAR);
         held_count = 0;
         put(c, KIND_CHAR);
         has_text = 1'b1;
      end
   endfunction

   // A quote opens a quoted part only while the field holds nothing but
   // whitespace; later quotes are ordinary text.
   function automatic void take_unquoted(logic [7:0] c);
      if ((c == CH_DQUOTE || c == CH_SQUOTE) && !has_text) begin
         quoted = 1'b1;
         single_quoted = (c == CH_SQUOTE);
         quote_seen = 1'b0;
      end else if (c == CH_COMMA) begin
         put(8'h00, KIND_FIELD_END);
         end_field();
      end else begin
         take_char(c);
      end
   endfunction

   function automatic void split_item(req_type item);
      logic [7:0] close_quote;
      int         k;
      close_quote = single_quoted ? CH_SQUOTE : CH_DQUOTE;
      item_results.delete();
      if (item.end_of_line) begin
         put(8'h00, KIND_LINE_END);
         end_field();
      end else if (quoted && quote_seen) begin
         quote_seen = 1'b0;
         if (item.ch == close_quote) begin
            take_char(item.ch);
         end else begin
            quoted = 1'b0;
            single_quoted = 1'b0;
            take_unquoted(item.ch);
         end
      end else if (quoted) begin
         if (item.ch == close_quote) quote_seen = 1'b1;
         else take_char(item.ch);
      end else begin
         take_unquoted(item.ch);
      end
      if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
      for (k = 0; k < item_results.size(); k++) results_due.push_back(item_results[k]);
   endfunction

   task automatic report(string what);
      error_count++;
      if (error_count <= 50) $display("csv_field_checker: result %0d: %s", result_count, what);
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s is 'h%0h, expected 'h%0h", name, got, want));
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (results_due.size() == 0) begin
         report($sformatf("unexpected result, char 'h%02h kind %0d", got.out_char, got.kind));
      end else begin
         want = results_due.pop_front();
         compare_field("out_char", got.out_char, want.out_char);
         compare_field("kind", got.kind, want.kind);
         compare_field("space_overflow", got.space_overflow, want.space_overflow);
         compare_field("last", got.last, want.last);
         if (want.kind != KIND_CHAR) field_count++;
      end
      result_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         end_field();
         results_due.delete();
         error_count = 0;
         item_count = 0;
         result_count = 0;
         field_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) begin
            split_item(req_data);
            item_count++;
         end
      end
      pending <= results_due.size();
   end

endmodule

// File: dv/csv_quoted_field_splitter_test.sv
// ----------------------------------------------------------------------------
// CSV quoted field splitter test
// Drives short directed lines and then random CSV lines with plain, quoted,
// padded, overflowing and noisy fields, with random gaps and stalls on both
// channels. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter_test;
   import csvqs_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RUN_LIMIT   = 12 * 1000000;
   localparam int ITEM_TARGET = 320;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int pending;
   int item_count;
   int result_count;
   int field_count;
   int sent_count = 0;
   int req_idle_mode = 0;
   int rsp_idle_mode = 0;
   int stall_run = 0;

   csv_quoted_field_splitter i_dut (.*);
   csv_field_checker i_checker (.*);

   always #HALF_PERIOD clock = ~clock;

   // Mode 0 never idles, mode 1 idles now and then, mode 2 idles often.
   function automatic int pick_gap(int mode);
      int roll;
      if (mode == 0) return 0;
      roll = $urandom_range(0, 99);
      if (roll < ((mode == 1) ? 65 : 30)) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= (rsp_idle_mode != 0) && ($urandom_range(0, 1) == 1);
         stall_run <= pick_gap(rsp_idle_mode);
      end
   end

   task automatic send_item(logic [7:0] c, logic eol);
      int gap;
      gap = pick_gap(req_idle_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{ch: c, end_of_line: eol};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_char(logic [7:0] c);
      send_item(c, 1'b0);
   endtask

   task automatic send_eol();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_string(string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_blanks(int n);
      logic [7:0] blanks [8];
      blanks = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0};
      repeat (n) send_char(blanks[$urandom_range(0, 7)]);
   endtask

   task automatic send_text(int n);
      logic [7:0] c;
      repeat (n) begin
         do c = 8'($urandom_range(0, 255));
         while (c inside {[8'h09:8'h0D], 8'h20, 8'h85, 8'hA0, CH_DQUOTE, CH_SQUOTE, CH_COMMA});
         send_char(c);
      end
   endtask

   task automatic send_field(logic closes_line);
      int         style;
      logic [7:0] q;
      logic [7:0] other;
      style = $urandom_range(0, 9);
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      other = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
      send_blanks($urandom_range(0, 3));
      case (style)
         0, 1, 2: begin
            repeat ($urandom_range(1, 3)) begin
               send_text($urandom_range(1, 4));
               if ($urandom_range(0, 1)) send_blanks($urandom_range(1, 3));
            end
            if ($urandom_range(0, 3) == 0) send_char(q);
         end
         3, 4, 5, 9: begin
            send_char(q);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 4))
                  0: send_text($urandom_range(1, 3));
                  1: send_blanks($urandom_range(1, 3));
                  2: send_char(CH_COMMA);
                  3: begin
                     send_char(q);
                     send_char(q);
                  end
                  default: send_char(other);
               endcase
            end
            // A quoted part left open is closed by the end of the line.
            if (!(closes_line && style == 9)) begin
               send_char(q);
               case ($urandom_range(0, 3))
                  0: ;
                  1: send_blanks($urandom_range(1, 3));
                  2: send_text($urandom_range(1, 2));
                  default: begin
                     send_char(other);
                     send_text(1);
                  end
               endcase
            end
         end
         6: begin
            send_text($urandom_range(1, 2));
            send_blanks($urandom_range(15, 20));
            if ($urandom_range(0, 1)) send_text(1);
         end
         7: repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
         default: ;
      endcase
      send_blanks($urandom_range(0, 2));
   endtask

   task automatic send_line();
      int n;
      int i;
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
         send_field(i == n - 1);
         if (i < n - 1) send_char(CH_COMMA);
      end
      send_eol();
   endtask

   task automatic send_noise_line();
      repeat ($urandom_range(4, 16))
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      send_eol();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      req_idle_mode = 1;
      rsp_idle_mode = 1;

      send_item(8'hFF, 1'b1);
      send_char(8'h20);
      send_char(8'h00);
      send_char(8'h09);
      send_char(8'hFF);
      send_char(8'hA0);
      send_char(CH_COMMA);
      send_string("\"a,\"\"\"b'");
      send_eol();
      send_string(" 'x'");
      send_eol();
      send_string("\"x");
      send_eol();

      while (sent_count < ITEM_TARGET) begin
         req_idle_mode = $urandom_range(0, 2);
         rsp_idle_mode = $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) send_noise_line();
         else send_line();
      end
      req_valid <= 1'b0;
      rsp_idle_mode = 0;

      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("Summary: %0d items sent, %0d results checked, %0d of them field or line ends.",
               item_count, result_count, field_count);
      if (error_count == 0 && pending == 0) begin
         $display("csv_quoted_field_splitter_test: clean");
      end else begin
         $display("csv_quoted_field_splitter_test: errors");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("csv_quoted_field_splitter_test: errors");
      $finish;
   end

endmodule
